/* design/ecnmfe_pkg.sv */
// ecnmfe_pkg: widths, codes and register indexes for the ECN marked fraction estimator.
// Used by ecnmfe_divider and ecn_marked_fraction_estimator_top; depends on nothing.
`timescale 1ns / 1ps
package ecnmfe_pkg;

    // Alpha full scale is 2^ALPHA_BITS; alpha itself needs one bit more
    localparam int ALPHA_BITS = 10;
    localparam int ALPHA_W    = ALPHA_BITS + 1;
    localparam logic [ALPHA_W-1:0] ALPHA_MAX = ALPHA_W'(1) << ALPHA_BITS;

    localparam int SEQ_W   = 32;
    localparam int MSS_W   = 16;
    localparam int GAIN_W  = 4;
    localparam int MODE_W  = 2;
    localparam int SHIFT_W = $clog2(ALPHA_BITS + 1);

    // Divider numerator: marked bytes shifted left by up to ALPHA_BITS
    localparam int NUM_W = SEQ_W + ALPHA_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    // Input item kinds
    localparam logic [MODE_W-1:0] MODE_ACK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOSS  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_START = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = ALPHA_W;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_SHIFT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ALPHA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_ON_LOSS = 2'd2;

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 4'd4;

    // Input and output beat widths (tdata)
    localparam int IN_DATA_W = 88;
    localparam int OUT_DATA_W = 16;

endpackage

/* design/ecn_marked_fraction_estimator_top.sv */
// ecn_marked_fraction_estimator_top: per-flow DCTCP alpha estimator with its sequencer.
// Depends on ecnmfe_pkg and instantiates ecnmfe_divider for the round-end division.
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  s_tdata (event fields), s_tuser (mode)
//  m_*       out        m_tvalid / m_tready  m_tdata (alpha, round_done)
//  cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A start, a loss or the spare mode passes the DELTA and EMIT steps to the output register,
// an ACK that leaves the round open DELTA, ACCUM and EMIT; an ACK that closes a round also
// passes LAUNCH, DIV and UPDATE, the serial divider producing one quotient bit a cycle.
// s_tready is high only while the sequencer idles; a result waiting in the output
// register does not block the next beat, which stalls only at its own emit step.
// Reset clears all estimator state and loads the register reset values; cfg_ready is high.
`timescale 1ns / 1ps
module ecn_marked_fraction_estimator_top
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    // s_tdata: ack_seq[31:0], next_send_seq[63:32], ece_flag[64],
    //          window_update_flag[65], recv_mss[81:66], ecn_capable[82], zero[87:83]
    input  logic [ecnmfe_pkg::IN_DATA_W-1:0]        s_tdata,
    // s_tuser: mode[1:0]
    input  logic [ecnmfe_pkg::MODE_W-1:0]           s_tuser,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // m_tdata: alpha[10:0], round_done[11], zero[15:12]
    output logic [ecnmfe_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [ecnmfe_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ecnmfe_pkg::CFG_DATA_W-1:0]       cfg_data
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DELTA  = 3'd1;
    localparam logic [2:0] ST_ACCUM  = 3'd2;
    localparam logic [2:0] ST_LAUNCH = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_UPDATE = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;

    localparam int SEQ_W   = ecnmfe_pkg::SEQ_W;
    localparam int ALPHA_W = ecnmfe_pkg::ALPHA_W;

    logic [2:0] state_reg, state_next;

    // Configuration registers
    logic [ecnmfe_pkg::GAIN_W-1:0] gain_reg;
    logic [ALPHA_W-1:0]            init_alpha_reg;
    logic                          clamp_reg;

    // Estimator state
    logic [SEQ_W-1:0]   last_acked_reg, last_acked_next;
    logic [SEQ_W-1:0]   round_end_reg, round_end_next;
    logic [SEQ_W-1:0]   marked_reg, marked_next;
    logic [SEQ_W-1:0]   total_reg, total_next;
    logic [ALPHA_W-1:0] alpha_reg, alpha_next;

    // Latched event fields
    logic [ecnmfe_pkg::MODE_W-1:0] mode_reg;
    logic [SEQ_W-1:0]              ack_reg;
    logic [SEQ_W-1:0]              nxt_reg;
    logic                          ece_reg;
    logic                          winupd_reg;
    logic [ecnmfe_pkg::MSS_W-1:0]  mss_reg;
    logic                          ecn_reg;

    // Working values between steps
    logic [SEQ_W-1:0] acked_reg, acked_next;
    logic             close_reg, close_next;
    logic             done_flag_reg, done_flag_next;

    // Output register
    logic [ALPHA_W-1:0] out_alpha_reg;
    logic               out_done_reg;
    logic               out_valid_reg, out_valid_next;

    logic accept;
    logic [SEQ_W-1:0] seq_diff;
    logic [SEQ_W-1:0] round_diff;
    logic [ecnmfe_pkg::SHIFT_W-1:0] gain_ext;
    logic [ecnmfe_pkg::SHIFT_W-1:0] gain_eff;
    logic [ecnmfe_pkg::SHIFT_W-1:0] num_shift;
    logic [ecnmfe_pkg::NUM_W-1:0]   div_numer;
    logic [SEQ_W-1:0]               div_denom;
    logic                           div_start;
    logic                           div_done;
    logic [ecnmfe_pkg::NUM_W-1:0]   div_quot;
    logic [ALPHA_W-1:0]             quot_sat;
    logic [ALPHA_W-1:0]             alpha_decay;
    logic [ALPHA_W:0]               alpha_sum;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Register writes; an index past the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg       <= ecnmfe_pkg::GAIN_RESET;
            init_alpha_reg <= '0;
            clamp_reg      <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ecnmfe_pkg::REG_GAIN_SHIFT:    gain_reg       <= cfg_data[ecnmfe_pkg::GAIN_W-1:0];
                ecnmfe_pkg::REG_INITIAL_ALPHA: init_alpha_reg <= cfg_data;
                ecnmfe_pkg::REG_CLAMP_ON_LOSS: clamp_reg      <= cfg_data[0];
                default:                       ;
            endcase
        end
    end

    // Hold the event fields for the steps that follow acceptance
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= s_tuser;
            ack_reg    <= s_tdata[31:0];
            nxt_reg    <= s_tdata[63:32];
            ece_reg    <= s_tdata[64];
            winupd_reg <= s_tdata[65];
            mss_reg    <= s_tdata[81:66];
            ecn_reg    <= s_tdata[82];
        end
    end

    // Bytes newly acknowledged, and distance of snd_una past the round end
    assign seq_diff   = ack_reg - last_acked_reg;
    assign round_diff = ack_reg - round_end_reg;

    // Gain above ALPHA_BITS saturates to ALPHA_BITS
    assign gain_ext  = ecnmfe_pkg::SHIFT_W'(gain_reg);
    assign gain_eff  = (gain_ext > ecnmfe_pkg::SHIFT_W'(ecnmfe_pkg::ALPHA_BITS))
                       ? ecnmfe_pkg::SHIFT_W'(ecnmfe_pkg::ALPHA_BITS) : gain_ext;
    assign num_shift = ecnmfe_pkg::SHIFT_W'(ecnmfe_pkg::ALPHA_BITS) - gain_eff;

    // Divider operands: wide numerator, total forced to at least one
    assign div_numer = ecnmfe_pkg::NUM_W'(marked_reg) << num_shift;
    assign div_denom = (total_reg == '0) ? SEQ_W'(1) : total_reg;
    assign div_start = (state_reg == ST_LAUNCH);

    ecnmfe_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (div_numer),
        .denom    (div_denom),
        .done     (div_done),
        .quotient (div_quot)
    );

    // A quotient beyond the alpha range can only clamp, so saturate it first
    assign quot_sat    = (|div_quot[ecnmfe_pkg::NUM_W-1:ALPHA_W]) ? '1 : div_quot[ALPHA_W-1:0];
    assign alpha_decay = alpha_reg - (alpha_reg >> gain_eff);
    assign alpha_sum   = {1'b0, alpha_decay} + {1'b0, quot_sat};

    always_comb
    begin
        state_next      = state_reg;
        last_acked_next = last_acked_reg;
        round_end_next  = round_end_reg;
        marked_next     = marked_reg;
        total_next      = total_reg;
        alpha_next      = alpha_reg;
        acked_next      = acked_reg;
        close_next      = close_reg;
        done_flag_next  = done_flag_reg;
        out_valid_next  = out_valid_reg;

        // Drop the output beat once taken
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    done_flag_next = 1'b0;
                    state_next     = ST_DELTA;
                end
            end
            ST_DELTA:
            begin
                state_next = ST_EMIT;
                case (mode_reg)
                    ecnmfe_pkg::MODE_START:
                    begin
                        if (ecn_reg)
                        begin
                            last_acked_next = ack_reg;
                            round_end_next  = nxt_reg;
                            marked_next     = '0;
                            total_next      = '0;
                            alpha_next      = (init_alpha_reg < ecnmfe_pkg::ALPHA_MAX)
                                              ? init_alpha_reg : ecnmfe_pkg::ALPHA_MAX;
                        end
                        else
                        begin
                            alpha_next = '0;
                        end
                    end
                    ecnmfe_pkg::MODE_LOSS:
                    begin
                        if (clamp_reg)
                        begin
                            alpha_next = ecnmfe_pkg::ALPHA_MAX;
                        end
                    end
                    ecnmfe_pkg::MODE_ACK:
                    begin
                        // Duplicate ACK counts one segment unless a window update
                        acked_next = (seq_diff == '0 && !winupd_reg)
                                     ? SEQ_W'(mss_reg) : seq_diff;
                        close_next = !round_diff[SEQ_W-1];
                        state_next = ST_ACCUM;
                    end
                    default:
                    begin
                        state_next = ST_EMIT;
                    end
                endcase
            end
            ST_ACCUM:
            begin
                if (acked_reg != '0)
                begin
                    total_next      = total_reg + acked_reg;
                    last_acked_next = ack_reg;
                    if (ece_reg)
                    begin
                        marked_next = marked_reg + acked_reg;
                    end
                end
                state_next = close_reg ? ST_LAUNCH : ST_EMIT;
            end
            ST_LAUNCH:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                alpha_next     = (alpha_sum > {1'b0, ecnmfe_pkg::ALPHA_MAX})
                                 ? ecnmfe_pkg::ALPHA_MAX : alpha_sum[ALPHA_W-1:0];
                marked_next    = '0;
                total_next     = '0;
                round_end_next = nxt_reg;
                done_flag_next = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Advance once the output register is free or being drained
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            last_acked_reg <= '0;
            round_end_reg  <= '0;
            marked_reg     <= '0;
            total_reg      <= '0;
            alpha_reg      <= '0;
            close_reg      <= 1'b0;
            done_flag_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            last_acked_reg <= last_acked_next;
            round_end_reg  <= round_end_next;
            marked_reg     <= marked_next;
            total_reg      <= total_next;
            alpha_reg      <= alpha_next;
            close_reg      <= close_next;
            done_flag_reg  <= done_flag_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers: working byte count and the output beat
    always_ff @(posedge clk)
    begin
        acked_reg <= acked_next;
        if (state_reg == ST_EMIT && (!out_valid_reg || m_tready))
        begin
            out_alpha_reg <= alpha_reg;
            out_done_reg  <= done_flag_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(ecnmfe_pkg::OUT_DATA_W - ALPHA_W - 1){1'b0}}, out_done_reg, out_alpha_reg};

endmodule

/* design/ecnmfe_divider.sv */
// ecnmfe_divider: restoring radix-2 divider, one quotient bit per cycle.
// Depends on ecnmfe_pkg for the numerator, denominator and counter widths.
`timescale 1ns / 1ps
module ecnmfe_divider
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [ecnmfe_pkg::NUM_W-1:0]    numer,
    input  logic [ecnmfe_pkg::SEQ_W-1:0]    denom,
    output logic                            done,
    output logic [ecnmfe_pkg::NUM_W-1:0]    quotient
);

    logic [ecnmfe_pkg::SEQ_W-1:0] rem_reg, rem_next;
    logic [ecnmfe_pkg::NUM_W-1:0] quo_reg, quo_next;
    logic [ecnmfe_pkg::SEQ_W-1:0] den_reg, den_next;
    logic [ecnmfe_pkg::CNT_W-1:0] count_reg, count_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;

    logic [ecnmfe_pkg::SEQ_W:0]   trial;
    logic [ecnmfe_pkg::SEQ_W:0]   diff;
    logic                         fits;

    // Bring down the next numerator bit and try the subtraction
    assign trial = {rem_reg, quo_reg[ecnmfe_pkg::NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = !diff[ecnmfe_pkg::SEQ_W];

    always_comb
    begin
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        den_next   = den_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            rem_next   = '0;
            quo_next   = numer;
            den_next   = denom;
            count_next = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? diff[ecnmfe_pkg::SEQ_W-1:0] : trial[ecnmfe_pkg::SEQ_W-1:0];
            quo_next   = {quo_reg[ecnmfe_pkg::NUM_W-2:0], fits};
            count_next = count_reg + 1'b1;
            if (count_reg == ecnmfe_pkg::CNT_W'(ecnmfe_pkg::NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking bench for ecn_marked_fraction_estimator_top, the per-flow DCTCP
// alpha estimator. Predicts every result beat in-bench and compares alpha and round_done.
// Depends on ecnmfe_pkg and the design sources only.
`timescale 1ns / 1ps
module tb_top;

    import ecnmfe_pkg::*;

    // Codes the package leaves unnamed: the spare mode and the spare register slot
    localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

    // Run limit for the watchdog, above the slowest legal run
    localparam int CYCLE_LIMIT   = 600_000;
    localparam int DRAIN_CYCLES  = 3 + NUM_W + 2 + 10;
    localparam int BEATS_PER_RUN = 200;

    // One input beat, ack_seq in the lowest bits as on s_tdata
    typedef struct packed {
        logic              ecn_capable;
        logic [MSS_W-1:0]  recv_mss;
        logic              window_update;
        logic              ece;
        logic [SEQ_W-1:0]  next_send;
        logic [SEQ_W-1:0]  ack_seq;
    } ack_beat_t;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic               round_done;
    } alpha_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [MODE_W-1:0]     s_tuser   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    ecn_marked_fraction_estimator_top DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Estimator shadow: register copies and flow state, updated on every
    // accepted configuration write and event beat
    // ------------------------------------------------------------------
    logic [GAIN_W-1:0]  cfg_gain_shift    = GAIN_RESET;
    logic [ALPHA_W-1:0] cfg_initial_alpha = '0;
    logic               cfg_clamp_on_loss = 1'b0;

    logic [SEQ_W-1:0]   est_last_acked = '0;
    logic [SEQ_W-1:0]   est_round_end  = '0;
    logic [SEQ_W-1:0]   est_marked     = '0;
    logic [SEQ_W-1:0]   est_total      = '0;
    logic [ALPHA_W-1:0] est_alpha      = '0;

    // Results owed by the block, oldest first
    alpha_result_t alpha_due_q[$];
    int unsigned   mismatch_count = 0;

    function automatic alpha_result_t estimate_alpha(input logic [MODE_W-1:0] mode,
                                                     input ack_beat_t beat);
        alpha_result_t     res;
        logic [SEQ_W-1:0]  acked;
        logic [SEQ_W-1:0]  seq_gap;
        logic [GAIN_W-1:0] gain;
        logic [63:0]       numer;
        logic [63:0]       denom;
        logic [63:0]       next_alpha;
        res.round_done = 1'b0;
        case (mode)
            MODE_START:
            begin
                if (beat.ecn_capable)
                begin
                    est_last_acked = beat.ack_seq;
                    est_alpha      = (cfg_initial_alpha > ALPHA_MAX) ? ALPHA_MAX
                                                                     : cfg_initial_alpha;
                    est_round_end  = beat.next_send;
                    est_marked     = '0;
                    est_total      = '0;
                end
                else
                begin
                    est_alpha = '0;
                end
            end
            MODE_LOSS:
            begin
                if (cfg_clamp_on_loss)
                    est_alpha = ALPHA_MAX;
            end
            MODE_ACK:
            begin
                acked = beat.ack_seq - est_last_acked;
                // A duplicate ACK counts one segment unless it only moved the window
                if (acked == '0 && !beat.window_update)
                    acked = SEQ_W'(beat.recv_mss);
                if (acked != '0)
                begin
                    est_total      = est_total + acked;
                    est_last_acked = beat.ack_seq;
                    if (beat.ece)
                        est_marked = est_marked + acked;
                end
                // Round closes once snd_una is not before the round end (serial compare)
                seq_gap = beat.ack_seq - est_round_end;
                if (!seq_gap[SEQ_W-1])
                begin
                    gain       = (cfg_gain_shift > ALPHA_BITS) ? GAIN_W'(ALPHA_BITS)
                                                               : cfg_gain_shift;
                    denom      = (est_total == '0) ? 64'd1 : 64'(est_total);
                    numer      = 64'(est_marked) << (ALPHA_BITS - gain);
                    next_alpha = 64'(est_alpha) - (64'(est_alpha) >> gain) + numer / denom;
                    est_alpha  = (next_alpha > 64'(ALPHA_MAX)) ? ALPHA_MAX
                                                               : next_alpha[ALPHA_W-1:0];
                    est_round_end  = beat.next_send;
                    est_marked     = '0;
                    est_total      = '0;
                    res.round_done = 1'b1;
                end
            end
            default:
            begin
                // spare mode: state untouched
            end
        endcase
        res.alpha = est_alpha;
        return res;
    endfunction

    function automatic void note_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    endfunction

    // ------------------------------------------------------------------
    // Result check: pop the oldest expectation on every accepted beat.
    // Values read straight after the edge are the pre-edge ones.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        alpha_result_t due;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (alpha_due_q.size() == 0)
            begin
                note_mismatch("result with nothing due", '0, 32'(m_tdata));
            end
            else
            begin
                due = alpha_due_q.pop_front();
                if (m_tdata[ALPHA_W-1:0] !== due.alpha)
                    note_mismatch("alpha", 32'(due.alpha), 32'(m_tdata[ALPHA_W-1:0]));
                if (m_tdata[ALPHA_W] !== due.round_done)
                    note_mismatch("round_done", 32'(due.round_done), 32'(m_tdata[ALPHA_W]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: its own stall pattern, in repeating segments of always
    // ready, mostly ready, long stalls and coin-flip stalls
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned rx_cycle;
        int unsigned stall_left;
        rx_cycle   = 0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (stall_left != 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                case (rx_cycle[9:8])
                    2'd0: m_tready <= 1'b1;
                    2'd1: m_tready <= ($urandom_range(0, 3) != 0);
                    2'd2:
                    begin
                        m_tready <= 1'b1;
                        if ($urandom_range(0, 15) == 0)
                            stall_left = $urandom_range(5, 40);
                    end
                    default: m_tready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // Watchdog: a hung handshake ends the run here
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender: bursts of random length separated by random gaps
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;

    task automatic send_beat(input logic [MODE_W-1:0] mode, input ack_beat_t beat);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tuser  <= mode;
        s_tdata  <= IN_DATA_W'(beat);
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        alpha_due_q.push_back(estimate_alpha(mode, beat));
    endtask

    // Drop valid and hold until every owed result has arrived
    task automatic wait_drained();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (alpha_due_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_index <= index;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            REG_GAIN_SHIFT:    cfg_gain_shift    = value[GAIN_W-1:0];
            REG_INITIAL_ALPHA: cfg_initial_alpha = value;
            REG_CLAMP_ON_LOSS: cfg_clamp_on_loss = value[0];
            default:           ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic ack_beat_t make_beat(input logic [SEQ_W-1:0] ack_seq,
                                            input logic [SEQ_W-1:0] next_send,
                                            input logic ece, input logic window_update,
                                            input logic [MSS_W-1:0] recv_mss,
                                            input logic ecn_capable);
        ack_beat_t beat;
        beat.ack_seq       = ack_seq;
        beat.next_send     = next_send;
        beat.ece           = ece;
        beat.window_update = window_update;
        beat.recv_mss      = recv_mss;
        beat.ecn_capable   = ecn_capable;
        return beat;
    endfunction

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Register reset values: duplicate ACK at reset counts a full-size segment and
    // closes the first round; loss without clamp, the spare mode, a window update,
    // starts with and without ECN, and a round that closes with nothing counted.
    task automatic test_reset_defaults();
        send_beat(MODE_ACK,    make_beat('0, 32'h0000_1000, 1'b1, 1'b0, '1, 1'b0));
        send_beat(MODE_LOSS,   make_beat('1, '1, 1'b1, 1'b1, '1, 1'b1));
        send_beat(MODE_UNUSED, make_beat('1, '1, 1'b1, 1'b1, '1, 1'b1));
        send_beat(MODE_ACK,    make_beat('0, 32'h0000_2000, 1'b0, 1'b1, '1, 1'b0));
        send_beat(MODE_START,  make_beat(32'h1234_5678, 32'h1234_9999, 1'b0, 1'b0, '0, 1'b0));
        send_beat(MODE_START,  make_beat('1, '1, 1'b0, 1'b0, '0, 1'b1));
        send_beat(MODE_ACK,    make_beat('1, '0, 1'b0, 1'b0, '0, 1'b0));
    endtask

    // Gain zero, initial alpha above full scale, clamp on loss
    task automatic test_start_and_loss_clamp();
        wait_drained();
        write_register(REG_GAIN_SHIFT,    CFG_DATA_W'(0));
        write_register(REG_INITIAL_ALPHA, '1);
        write_register(REG_CLAMP_ON_LOSS, CFG_DATA_W'(1));
        send_beat(MODE_START, make_beat(32'd100, 32'd200, 1'b0, 1'b0, 16'd1460, 1'b1));
        send_beat(MODE_ACK,   make_beat(32'd150, 32'd300, 1'b0, 1'b0, 16'd1460, 1'b0));
        send_beat(MODE_ACK,   make_beat(32'd200, 32'd400, 1'b1, 1'b0, 16'd1460, 1'b0));
        send_beat(MODE_LOSS,  make_beat(32'd200, 32'd400, 1'b0, 1'b0, 16'd1460, 1'b0));
    endtask

    // Byte counters wrap across 2^32 inside one round; then a round with no bytes
    task automatic test_counter_wrap();
        wait_drained();
        write_register(REG_GAIN_SHIFT,    CFG_DATA_W'(ALPHA_BITS));
        write_register(REG_INITIAL_ALPHA, CFG_DATA_W'(ALPHA_MAX));
        write_register(REG_CLAMP_ON_LOSS, CFG_DATA_W'(0));
        send_beat(MODE_START, make_beat('0, 32'h4000_0000, 1'b0, 1'b0, '0, 1'b1));
        send_beat(MODE_ACK,   make_beat(32'hC000_0000, 32'hC000_1000, 1'b1, 1'b0, '0, 1'b0));
        send_beat(MODE_ACK,   make_beat(32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0, '0, 1'b0));
        send_beat(MODE_ACK,   make_beat(32'h8000_0000, 32'h8000_5000, 1'b1, 1'b0, '0, 1'b0));
        send_beat(MODE_LOSS,  make_beat('0, '0, 1'b0, 1'b0, '0, 1'b0));
    endtask

    // Gain beyond ten saturates; upper write bits are ignored; spare register slot
    task automatic test_gain_extremes();
        wait_drained();
        write_register(REG_GAIN_SHIFT, CFG_DATA_W'(15));
        write_register(REG_UNUSED,     '1);
        send_beat(MODE_START, make_beat(32'd0,    32'd1000, 1'b0, 1'b0, 16'd1460, 1'b1));
        send_beat(MODE_ACK,   make_beat(32'd1000, 32'd1000, 1'b1, 1'b0, 16'd1460, 1'b0));
        send_beat(MODE_ACK,   make_beat(32'd2000, 32'd3000, 1'b0, 1'b0, 16'd1460, 1'b0));
        wait_drained();
        write_register(REG_GAIN_SHIFT, CFG_DATA_W'('h7F0));
        send_beat(MODE_ACK,   make_beat(32'd2500, 32'd3000, 1'b1, 1'b0, 16'd1460, 1'b0));
        send_beat(MODE_ACK,   make_beat(32'd3000, 32'd4000, 1'b0, 1'b1, 16'd1460, 1'b0));
    endtask

    // ------------------------------------------------------------------
    // Random flows: mostly well-formed ACK streams with random content,
    // starts near the sequence wrap, loss events, and a share of noise
    // ------------------------------------------------------------------
    logic [SEQ_W-1:0] flow_una  = '0;
    logic [SEQ_W-1:0] flow_nxt  = '0;
    logic             flow_live = 1'b0;
    int unsigned      mark_pct  = 50;

    task automatic send_random_flow_beat();
        ack_beat_t        beat;
        logic [MODE_W-1:0] noise_mode;
        logic [SEQ_W-1:0] window_left;
        int unsigned      pick;
        int unsigned      step;
        beat.ack_seq       = $urandom();
        beat.next_send     = $urandom();
        beat.ece           = 1'($urandom_range(0, 1));
        beat.window_update = 1'($urandom_range(0, 1));
        beat.recv_mss      = MSS_W'($urandom_range(0, (1 << MSS_W) - 1));
        beat.ecn_capable   = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            // noise: any mode, any field values; sometimes abandon the flow
            noise_mode = MODE_W'($urandom_range(0, (1 << MODE_W) - 1));
            send_beat(noise_mode, beat);
            if ($urandom_range(0, 1) == 0)
                flow_live = 1'b0;
        end
        else if (!flow_live || pick < 9)
        begin
            flow_una = ($urandom_range(0, 3) == 0) ? 32'hFFFF_0000 + $urandom_range(0, 65535)
                                                   : $urandom();
            flow_nxt = flow_una + $urandom_range(1, 30000);
            beat.ack_seq     = flow_una;
            beat.next_send   = flow_nxt;
            beat.ecn_capable = ($urandom_range(0, 9) != 0);
            send_beat(MODE_START, beat);
            flow_live = beat.ecn_capable;
        end
        else if (pick < 14)
        begin
            beat.ack_seq   = flow_una;
            beat.next_send = flow_nxt;
            send_beat(MODE_LOSS, beat);
        end
        else
        begin
            step     = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 4000);
            flow_una = flow_una + step;
            window_left = flow_nxt - flow_una;
            // move snd_nxt ahead once snd_una has passed it, else sometimes advance it
            if (window_left[SEQ_W-1])
                flow_nxt = flow_una + $urandom_range(0, 20000);
            else if ($urandom_range(0, 1) == 0)
                flow_nxt = flow_nxt + $urandom_range(0, 3000);
            beat.ack_seq       = flow_una;
            beat.next_send     = flow_nxt;
            beat.ece           = ($urandom_range(1, 100) <= mark_pct);
            beat.window_update = (step == 0) ? 1'($urandom_range(0, 1))
                                             : ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 3) != 0)
                beat.recv_mss = 16'd1460;
            send_beat(MODE_ACK, beat);
        end
    endtask

    task automatic test_random_flows();
        logic [CFG_DATA_W-1:0] gain_word;
        logic [CFG_DATA_W-1:0] clamp_word;
        for (int run = 0; run < 4; run++)
        begin
            wait_drained();
            // extremes first, then random settings with junk in the unused bits
            gain_word  = {7'($urandom()), 4'($urandom_range(0, 15))};
            clamp_word = {10'($urandom()), 1'($urandom_range(0, 1))};
            case (run)
                0:
                begin
                    write_register(REG_GAIN_SHIFT,    CFG_DATA_W'(0));
                    write_register(REG_INITIAL_ALPHA, CFG_DATA_W'(ALPHA_MAX));
                    write_register(REG_CLAMP_ON_LOSS, CFG_DATA_W'(1));
                end
                1:
                begin
                    write_register(REG_GAIN_SHIFT,    CFG_DATA_W'(ALPHA_BITS));
                    write_register(REG_INITIAL_ALPHA, CFG_DATA_W'(0));
                    write_register(REG_CLAMP_ON_LOSS, CFG_DATA_W'(0));
                end
                default:
                begin
                    write_register(REG_GAIN_SHIFT,    gain_word);
                    write_register(REG_INITIAL_ALPHA, CFG_DATA_W'($urandom()));
                    write_register(REG_CLAMP_ON_LOSS, clamp_word);
                end
            endcase
            flow_live = 1'b0;
            for (int n = 0; n < BEATS_PER_RUN; n++)
            begin
                // vary the marking rate so alpha sweeps its range
                if (n % 50 == 0)
                    mark_pct = ($urandom_range(0, 3) == 0) ? 100 * $urandom_range(0, 1)
                                                           : $urandom_range(0, 100);
                send_random_flow_beat();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset once, directed tests, random flows, drain, verdict
    // ------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_start_and_loss_clamp();
        test_counter_wrap();
        test_gain_extremes();
        test_random_flows();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (alpha_due_q.size() != 0)
            note_mismatch("results never delivered", '0, 32'(alpha_due_q.size()));

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
